@@ rtl/nmru_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nmru_pkg
// Shared types and constants of the not-most-recently-used replacement block.
// ----------------------------------------------------------------------------
package nmru_pkg;

   localparam int DEF_WAYS     = 8;
   localparam int DEF_NUM_SETS = 64;

   // field widths
   localparam int FUNC_W     = 2;
   localparam int SET_IDX_W  = 6;
   localparam int WAY_IDX_W  = 3;
   localparam int TS_W       = 32;
   localparam int PICK_W     = 3;
   localparam int VICTIM_W   = 3;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_TOUCH      = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_INVALIDATE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_VICTIM     = 2'd2;

   // controller to compare unit
   typedef struct packed {
      logic load;
      logic step;
   } mru_ctrl_type;

endpackage
`default_nettype wire

@@ rtl/nmru_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nmru_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nmru_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ rtl/nmru_mru.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nmru_mru
// Most-recently-used finder: halving compare tree, one level per step, over
// the timestamps of one set row. Ties go to the lower way.
// ----------------------------------------------------------------------------
module nmru_mru #(
   parameter int WAYS = nmru_pkg::DEF_WAYS,
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  wire logic                               clock,
   input  wire nmru_pkg::mru_ctrl_type             ctrl,
   input  wire logic [WAYS*nmru_pkg::TS_W-1:0]     row,
   output logic      [WW-1:0]                      mru_way
);
   import nmru_pkg::*;

   localparam int LVLS = $clog2(WAYS);
   localparam int P    = 1 << LVLS;

   logic [TS_W-1:0] cand_val_ff [P];
   logic [TS_W-1:0] cand_val_in [P];
   logic [WW-1:0]   cand_idx_ff [P];
   logic [WW-1:0]   cand_idx_in [P];

   always_comb begin
      for (int i = 0; i < P; i++) begin
         cand_val_in[i] = cand_val_ff[i];
         cand_idx_in[i] = cand_idx_ff[i];
      end
      if (ctrl.load) begin
         // pad slots hold zero at the high end, so they never win a tie
         for (int i = 0; i < P; i++) begin
            cand_val_in[i] = (i < WAYS) ? row[i*TS_W +: TS_W] : '0;
            cand_idx_in[i] = WW'(i);
         end
      end else if (ctrl.step) begin
         for (int i = 0; i < P / 2; i++) begin
            if (cand_val_ff[2*i+1] > cand_val_ff[2*i]) begin
               cand_val_in[i] = cand_val_ff[2*i+1];
               cand_idx_in[i] = cand_idx_ff[2*i+1];
            end else begin
               cand_val_in[i] = cand_val_ff[2*i];
               cand_idx_in[i] = cand_idx_ff[2*i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < P; i++) begin
         cand_val_ff[i] <= cand_val_in[i];
         cand_idx_ff[i] <= cand_idx_in[i];
      end
   end

   assign mru_way = cand_idx_ff[0];

endmodule
`default_nettype wire

@@ rtl/nmru_replacement_policy_top.sv @@
`default_nettype none
// Touch / invalidate: row read at accept, row write-back in the RMW state; no response.
// Victim: tree load from the row read at accept, one compare level per cycle, then the
//   response register. No new word is taken until the response is registered; a held
//   response adds stalls.
// Reset: a clearing pass writes zero to all NUM_SETS rows, one row a cycle,
//   with req_stall held high for the whole pass.
// ----------------------------------------------------------------------------
// nmru_replacement_policy_top
// Not-most-recently-used replacement: per-way last-touch timestamps in a row
// memory, read-modify-write on touch and invalidate, MRU search and random pick on victim.
// ----------------------------------------------------------------------------
module nmru_replacement_policy_top #(
   parameter int WAYS     = nmru_pkg::DEF_WAYS,
   parameter int NUM_SETS = nmru_pkg::DEF_NUM_SETS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [nmru_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [nmru_pkg::SET_IDX_W-1:0]    req_set_index,
   input  wire logic [nmru_pkg::WAY_IDX_W-1:0]    req_way_index,
   input  wire logic [nmru_pkg::TS_W-1:0]         req_current_time,
   input  wire logic [nmru_pkg::PICK_W-1:0]       req_random_pick,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [nmru_pkg::VICTIM_W-1:0]     rsp_victim_way
);
   import nmru_pkg::*;

   localparam int WW       = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SW       = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int ROW_W    = WAYS * TS_W;
   localparam int LVLS     = $clog2(WAYS);
   localparam int LVL_W    = (LVLS > 1) ? $clog2(LVLS) : 1;
   localparam int PICK_MOD = (WAYS > 1) ? WAYS - 1 : 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RMW    = 3'd1;
   localparam logic [2:0] ST_LOAD   = 3'd2;
   localparam logic [2:0] ST_REDUCE = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   // constant reduction tables
   logic [SW-1:0] set_lut  [2**SET_IDX_W];
   logic [WW-1:0] pick_lut [2**PICK_W];

   for (genvar i = 0; i < 2**SET_IDX_W; i++) begin : g_set_lut
      assign set_lut[i] = SW'(i % NUM_SETS);
   end
   for (genvar i = 0; i < 2**PICK_W; i++) begin : g_pick_lut
      assign pick_lut[i] = (WAYS > 1) ? WW'(i % PICK_MOD) : '0;
   end

   logic [2:0]       state_ff, state_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic             clr_active_ff, clr_active_in;
   logic [SW-1:0]    clr_addr_ff, clr_addr_in;
   logic [SW-1:0]    set_ff, set_in;
   logic [WW-1:0]    way_ff, way_in;
   logic             way_ok_ff, way_ok_in;
   logic             is_touch_ff, is_touch_in;
   logic [TS_W-1:0]  time_ff, time_in;
   logic [WW-1:0]    pick_ff, pick_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VICTIM_W-1:0] rsp_way_ff, rsp_way_in;

   logic             accept;
   logic             ram_wr_en;
   logic [SW-1:0]    ram_wr_addr;
   logic [ROW_W-1:0] ram_wr_data;
   logic [ROW_W-1:0] ram_rd_data;
   logic [WW-1:0]    mru_way;
   logic [WW-1:0]    victim;
   mru_ctrl_type     mru_ctrl;

   assign req_stall = clr_active_ff || (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   nmru_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (set_lut[req_set_index]),
      .rd_data (ram_rd_data)
   );

   nmru_mru #(
      .WAYS (WAYS)
   ) u_mru (
      .clock   (clock),
      .ctrl    (mru_ctrl),
      .row     (ram_rd_data),
      .mru_way (mru_way)
   );

   // write port: clearing pass, else row write-back
   always_comb begin
      ram_wr_en   = clr_active_ff || ((state_ff == ST_RMW) && way_ok_ff);
      ram_wr_addr = clr_active_ff ? clr_addr_ff : set_ff;
      ram_wr_data = ram_rd_data;
      if (clr_active_ff) begin
         ram_wr_data = '0;
      end else begin
         for (int w = 0; w < WAYS; w++) begin
            if (way_ff == WW'(w)) begin
               ram_wr_data[w*TS_W +: TS_W] = is_touch_ff ? time_ff : '0;
            end
         end
      end
   end

   // skip the MRU way in ascending order
   assign victim = (WAYS > 1) ? ((pick_ff < mru_way) ? pick_ff : pick_ff + 1'b1) : mru_way;

   always_comb begin
      state_in      = state_ff;
      lvl_in        = lvl_ff;
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      set_in        = set_ff;
      way_in        = way_ff;
      way_ok_in     = way_ok_ff;
      is_touch_in   = is_touch_ff;
      time_in       = time_ff;
      pick_in       = pick_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_way_in    = rsp_way_ff;
      mru_ctrl.load = 1'b0;
      mru_ctrl.step = 1'b0;

      if (clr_active_ff) begin
         if (clr_addr_ff == SW'(NUM_SETS - 1)) begin
            clr_active_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               set_in      = set_lut[req_set_index];
               way_in      = WW'(req_way_index);
               way_ok_in   = int'(req_way_index) < WAYS;
               is_touch_in = (req_func == FUNC_TOUCH);
               time_in     = req_current_time;
               pick_in     = pick_lut[req_random_pick];
               if (req_func == FUNC_TOUCH || req_func == FUNC_INVALIDATE) begin
                  state_in = ST_RMW;
               end else if (req_func == FUNC_VICTIM) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_RMW: begin
            state_in = ST_IDLE;
         end
         ST_LOAD: begin
            mru_ctrl.load = 1'b1;
            lvl_in        = '0;
            state_in      = (LVLS == 0) ? ST_DONE : ST_REDUCE;
         end
         ST_REDUCE: begin
            mru_ctrl.step = 1'b1;
            if (lvl_ff == LVL_W'(LVLS - 1)) begin
               state_in = ST_DONE;
            end else begin
               lvl_in = lvl_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_way_in   = VICTIM_W'(victim);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lvl_ff        <= '0;
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lvl_ff        <= lvl_in;
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff      <= set_in;
      way_ff      <= way_in;
      way_ok_ff   <= way_ok_in;
      is_touch_ff <= is_touch_in;
      time_ff     <= time_in;
      pick_ff     <= pick_in;
      rsp_way_ff  <= rsp_way_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_victim_way = rsp_way_ff;

`ifndef SYNTH
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response word raised outside done state");

   a_no_write_on_victim: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD || state_ff == ST_REDUCE || state_ff == ST_DONE) |-> !ram_wr_en)
      else $error("row write during victim search");

   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> (state_ff == ST_IDLE && !rsp_valid_ff))
      else $error("activity during clearing pass");

   a_victim_load: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_VICTIM) |=> state_ff == ST_LOAD)
      else $error("victim word did not start row load");
`endif

endmodule
`default_nettype wire

@@ dv/nmru_replacement_policy_top_tb.sv @@
// ----------------------------------------------------------------------------
// nmru_replacement_policy_top_tb
// Self-checking bench for the NMRU replacement block. A directed table covers
// the corner cases: empty sets, the all-ones timestamp, ties for the MRU way,
// picks that wrap, invalidates and the unused code. Random traffic of all four codes,
// mostly over four hot sets, follows. Both sides stall at random. Each victim response
// is compared with the table's pinned way or with a behavioral model of the timestamp store.
// ----------------------------------------------------------------------------
module nmru_replacement_policy_top_tb;
   import nmru_pkg::*;

   localparam int WAYS       = DEF_WAYS;
   localparam int NUM_SETS   = DEF_NUM_SETS;
   localparam int N_RANDOM   = 1400;
   localparam int IDLE_LIMIT = 3000;
   localparam int N_DIRECTED = 22;

   // code with no operation behind it
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [SET_IDX_W-1:0] set_idx;
      logic [WAY_IDX_W-1:0] way;
      logic [TS_W-1:0]      stamp;
      logic [PICK_W-1:0]    pick;
      logic                 pinned;
      logic [VICTIM_W-1:0]  exp_way;
   } dir_row_type;

   logic clock;
   logic reset = 1'b1;

   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   logic [FUNC_W-1:0]    req_func         = FUNC_TOUCH;
   logic [SET_IDX_W-1:0] req_set_index    = '0;
   logic [WAY_IDX_W-1:0] req_way_index    = '0;
   logic [TS_W-1:0]      req_current_time = '0;
   logic [PICK_W-1:0]    req_random_pick  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic [VICTIM_W-1:0]  rsp_victim_way;

   // expectation typed into the table, travels with the word
   logic                pin_valid = 1'b0;
   logic [VICTIM_W-1:0] pin_way   = '0;

   logic [TS_W-1:0]     stamp_mem [NUM_SETS][WAYS];
   logic [VICTIM_W-1:0] victim_q [$];

   int  mismatch_cnt = 0;
   int  fail_cnt     = 0;
   int  idle_cycles  = 0;
   int  stall_hold   = 0;
   int  stall_roll;
   bit  calm_run     = 1'b0;
   bit  moved;

   // empty sets, all-ones stamp, MRU ties, wrapped pick, unused code
   dir_row_type dir_tab [N_DIRECTED] = '{
      '{FUNC_VICTIM,     6'd0,  3'd0, 32'h0,         3'd0, 1'b1, 3'd1},
      '{FUNC_VICTIM,     6'd63, 3'd7, 32'h0,         3'd7, 1'b1, 3'd1},
      '{FUNC_VICTIM,     6'd5,  3'd0, 32'h0,         3'd6, 1'b1, 3'd7},
      '{FUNC_TOUCH,      6'd0,  3'd7, 32'hFFFF_FFFF, 3'd0, 1'b0, 3'd0},
      '{FUNC_VICTIM,     6'd0,  3'd0, 32'h0,         3'd6, 1'b1, 3'd6},
      '{FUNC_VICTIM,     6'd0,  3'd0, 32'h0,         3'd0, 1'b1, 3'd0},
      '{FUNC_TOUCH,      6'd0,  3'd3, 32'hFFFF_FFFF, 3'd0, 1'b0, 3'd0},
      '{FUNC_VICTIM,     6'd0,  3'd0, 32'h0,         3'd3, 1'b1, 3'd4},
      '{FUNC_VICTIM,     6'd0,  3'd0, 32'h0,         3'd2, 1'b1, 3'd2},
      '{FUNC_INVALIDATE, 6'd0,  3'd3, 32'h1234_5678, 3'd0, 1'b0, 3'd0},
      '{FUNC_VICTIM,     6'd0,  3'd0, 32'h0,         3'd6, 1'b1, 3'd6},
      '{FUNC_UNUSED,     6'd0,  3'd7, 32'h5,         3'd5, 1'b0, 3'd0},
      '{FUNC_VICTIM,     6'd0,  3'd0, 32'h0,         3'd7, 1'b1, 3'd0},
      '{FUNC_TOUCH,      6'd63, 3'd0, 32'h1,         3'd0, 1'b0, 3'd0},
      '{FUNC_VICTIM,     6'd63, 3'd0, 32'h0,         3'd0, 1'b1, 3'd1},
      '{FUNC_TOUCH,      6'd63, 3'd4, 32'h2,         3'd0, 1'b0, 3'd0},
      '{FUNC_VICTIM,     6'd63, 3'd0, 32'h0,         3'd4, 1'b1, 3'd5},
      '{FUNC_VICTIM,     6'd63, 3'd0, 32'h0,         3'd3, 1'b1, 3'd3},
      '{FUNC_INVALIDATE, 6'd0,  3'd7, 32'h0,         3'd0, 1'b0, 3'd0},
      '{FUNC_VICTIM,     6'd0,  3'd0, 32'h0,         3'd5, 1'b1, 3'd6},
      '{FUNC_TOUCH,      6'd42, 3'd5, 32'h8000_0000, 3'd0, 1'b0, 3'd0},
      '{FUNC_VICTIM,     6'd42, 3'd0, 32'h0,         3'd5, 1'b1, 3'd6}
   };

   nmru_replacement_policy_top #(
      .WAYS     (WAYS),
      .NUM_SETS (NUM_SETS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_set_index    (req_set_index),
      .req_way_index    (req_way_index),
      .req_current_time (req_current_time),
      .req_random_pick  (req_random_pick),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_victim_way   (rsp_victim_way)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // first (lowest) way with the largest stamp is MRU; pick indexes the rest
   function automatic logic [VICTIM_W-1:0] nmru_victim(input int set_no,
                                                       input logic [PICK_W-1:0] pick);
      int mru;
      int r;
      mru = 0;
      for (int w = 1; w < WAYS; w++)
         if (stamp_mem[set_no][w] > stamp_mem[set_no][mru]) mru = w;
      if (WAYS <= 1) return VICTIM_W'(mru);
      r = int'(pick) % (WAYS - 1);
      return VICTIM_W'((r < mru) ? r : r + 1);
   endfunction

   function automatic void report_miss(input string what, input int exp_v, input int act_v);
      fail_cnt++;
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
         $display("ERROR %s: expected %0d, got %0d", what, exp_v, act_v);
   endfunction

   // append one expected victim at the tail of the queue
   function automatic void queue_victim(input logic [VICTIM_W-1:0] way_v);
      victim_q = {victim_q, way_v};
   endfunction

   // track the store and queue the victim each accepted word implies
   function automatic void take_word();
      int set_no;
      set_no = int'(req_set_index) % NUM_SETS;
      case (req_func)
         FUNC_TOUCH: begin
            if (int'(req_way_index) < WAYS) stamp_mem[set_no][req_way_index] = req_current_time;
         end
         FUNC_INVALIDATE: begin
            if (int'(req_way_index) < WAYS) stamp_mem[set_no][req_way_index] = '0;
         end
         FUNC_VICTIM: begin
            if (pin_valid) queue_victim(pin_way);
            else queue_victim(nmru_victim(set_no, req_random_pick));
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            moved = 1'b1;
            if (victim_q.size() == 0) report_miss("unexpected victim word", -1, rsp_victim_way);
            else begin
               logic [VICTIM_W-1:0] exp_way;
               exp_way = victim_q.pop_front();
               if (rsp_victim_way !== exp_way)
                  report_miss("victim_way", exp_way, rsp_victim_way);
            end
         end
         if (req_valid && req_stall === 1'b0) begin
            moved = 1'b1;
            take_word();
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("nmru_replacement_policy_top verification failed");
            $finish;
         end
      end
   end

   // response back-pressure: mostly open, short stalls, now and then a long one
   always @(posedge clock) begin
      if (calm_run) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         stall_roll = $urandom_range(99);
         if (stall_roll < 55) begin
            rsp_stall  <= 1'b0;
            stall_hold <= $urandom_range(12);
         end else if (stall_roll < 93) begin
            rsp_stall  <= 1'b1;
            stall_hold <= $urandom_range(3);
         end else begin
            rsp_stall  <= 1'b1;
            stall_hold <= $urandom_range(40, 15);
         end
      end
   end

   function automatic int sender_gap();
      int roll;
      if (calm_run) return 0;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(30, 10);
   endfunction

   task automatic send_word(input logic [FUNC_W-1:0] func, input logic [SET_IDX_W-1:0] set_idx,
                            input logic [WAY_IDX_W-1:0] way, input logic [TS_W-1:0] stamp,
                            input logic [PICK_W-1:0] pick, input logic pinned,
                            input logic [VICTIM_W-1:0] exp_way);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_set_index    <= set_idx;
      req_way_index    <= way;
      req_current_time <= stamp;
      req_random_pick  <= pick;
      pin_valid        <= pinned;
      pin_way          <= exp_way;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   // hold the sender until every queued victim has come back
   task automatic drain_victims();
      req_valid <= 1'b0;
      @(posedge clock);
      while (victim_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [SET_IDX_W-1:0] hot_sets [4];
      logic [FUNC_W-1:0]    func;
      logic [TS_W-1:0]      now_ts;
      logic [TS_W-1:0]      stamp;
      int                   roll;
      int                   sent;

      for (int s = 0; s < NUM_SETS; s++)
         for (int w = 0; w < WAYS; w++) stamp_mem[s][w] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i])
         send_word(dir_tab[i].func, dir_tab[i].set_idx, dir_tab[i].way, dir_tab[i].stamp,
                   dir_tab[i].pick, dir_tab[i].pinned, dir_tab[i].exp_way);
      drain_victims();

      now_ts = 32'd100;
      sent   = 0;
      while (sent < N_RANDOM) begin
         if (sent % 200 == 0)
            foreach (hot_sets[k]) hot_sets[k] = SET_IDX_W'($urandom_range(NUM_SETS - 1));
         if (sent == N_RANDOM / 2) drain_victims();
         calm_run = (sent >= 300 && sent < 420);

         now_ts = now_ts + TS_W'($urandom_range(5, 1));
         roll   = $urandom_range(99);
         if (roll < 88) stamp = now_ts;
         else if (roll < 94) stamp = TS_W'($urandom);
         else if (roll < 97) stamp = 32'hFFFF_FFFF;
         else stamp = '0;

         roll = $urandom_range(99);
         if (roll < 45) func = FUNC_TOUCH;
         else if (roll < 55) func = FUNC_INVALIDATE;
         else if (roll < 95) func = FUNC_VICTIM;
         else func = FUNC_UNUSED;

         send_word(func,
                   ($urandom_range(99) < 80) ? hot_sets[$urandom_range(3)]
                                             : SET_IDX_W'($urandom_range(NUM_SETS - 1)),
                   WAY_IDX_W'($urandom_range(7)), stamp, PICK_W'($urandom_range(7)),
                   1'b0, '0);
         if (func != FUNC_UNUSED) sent++;
      end
      calm_run = 1'b0;

      drain_victims();
      repeat (20) @(posedge clock);
      if (fail_cnt == 0 && victim_q.size() == 0)
         $display("nmru_replacement_policy_top verification clean");
      else
         $display("nmru_replacement_policy_top verification failed");
      $finish;
   end

endmodule
